// ===== design/mfdx_pkg.sv =====
// shared constants and types for the marker-framed byte deframer
// no dependencies; imported by marker_frame_deframer_xor_check and its testbench
package mfdx_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned DataBytes   = 8;   // data bytes per frame
  localparam int unsigned CheckBytes  = 7;   // bytes folded into the xor check
  localparam int unsigned CountW      = 4;
  localparam int unsigned StoreIdxW   = $clog2(DataBytes);
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned OutW        = ByteW * DataBytes;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'd170;
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'd85;

  // register indexes on the config channel
  localparam logic [CfgIdxW-1:0] CfgStartMarker = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgEndMarker   = 8'd1;

  localparam logic [CountW-1:0] CountEnd   = CountW'(DataBytes);
  localparam logic [CountW-1:0] CountCheck = CountW'(CheckBytes);

  typedef enum logic [1:0] {
    ST_HUNT  = 2'b01,
    ST_FRAME = 2'b10
  } state_e;

  typedef logic [ByteW-1:0] byte_t;

endpackage

// ===== design/marker_frame_deframer_xor_check.sv =====
// marker-framed byte deframer with xor check, top level
// depends on mfdx_pkg
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tdata[7:0] rx_byte
//  m_axis   | out | m_axis_tvalid/tready    | tdata[63:0] data_byte_0..7
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one byte per cycle while s_axis_tready is high; each byte is handled by a compare and an xor update
// straight into the frame state, a good frame lands in the output register
// in the cycle after its end byte. the config channel is always ready.
// reset clears the frame state and loads the marker reset values.
// a held output word stalls the input only when the next byte would close a frame.
module marker_frame_deframer_xor_check
  import mfdx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OutW-1:0]    m_axis_tdata,   // data_byte_0 in [7:0] up to data_byte_7 in [63:56]
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  state_e            state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  byte_t             xor_q, xor_d;
  byte_t             store_q [DataBytes];
  byte_t             start_q, end_q;
  logic              out_valid_q, out_valid_d;
  logic [OutW-1:0]   out_data_q;

  logic in_fire, cfg_fire, at_end, frame_ok, load_out;

  assign at_end   = (state_q == ST_FRAME) && (cnt_q >= CountEnd);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign frame_ok = (s_axis_tdata == end_q) && (xor_q == store_q[DataBytes-1]);
  assign load_out = in_fire && at_end && frame_ok;

  assign s_axis_tready = !(at_end && out_valid_q && !m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    if (in_fire) begin
      case (state_q)
        ST_HUNT: begin
          if (s_axis_tdata == start_q) begin
            state_d = ST_FRAME;
            cnt_d   = '0;
            xor_d   = '0;
          end
        end
        ST_FRAME: begin
          if (at_end) begin
            state_d = ST_HUNT;
            cnt_d   = '0;
            xor_d   = '0;
          end else begin
            cnt_d = cnt_q + CountW'(1);
            if (cnt_q < CountCheck) begin
              xor_d = xor_q ^ s_axis_tdata;
            end
          end
        end
        default: begin
          state_d = ST_HUNT;
          cnt_d   = '0;
          xor_d   = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      cnt_q       <= '0;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
      start_q     <= StartMarkerRst;
      end_q       <= EndMarkerRst;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          CfgStartMarker: start_q <= cfg_data_i;
          CfgEndMarker:   end_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // frame store and output word carry no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && (state_q == ST_FRAME) && !at_end) begin
      store_q[cnt_q[StoreIdxW-1:0]] <= s_axis_tdata;
    end
    if (load_out) begin
      for (int i = 0; i < DataBytes; i++) begin
        out_data_q[i*ByteW +: ByteW] <= store_q[i];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountEnd)
    else $error("byte count ran past the end byte");

  a_hunt_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HUNT) |-> (cnt_q == '0 && xor_q == '0))
    else $error("hunt state with stale frame count or xor");

  a_end_returns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && at_end) |=> (state_q == ST_HUNT))
    else $error("end byte did not return to hunting");

  a_word_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FRAME && cnt_q == CountEnd && in_fire))
    else $error("output word appeared without an accepted end byte");

endmodule

// ===== tb/tb_marker_frame_deframer_xor_check.sv =====
`timescale 1ns / 1ps
// self-checking testbench for marker_frame_deframer_xor_check
// depends on mfdx_pkg; predicts good frames from accepted bytes and checks m_axis words
module tb_marker_frame_deframer_xor_check;
  import mfdx_pkg::*;

  typedef logic [DataBytes-1:0][ByteW-1:0] frame_t;  // data_byte_0 in the low byte

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseBytes = 250;
  localparam int unsigned IdlePct    = 16;
  localparam logic [CfgIdxW-1:0] CfgPastEnd = CfgEndMarker + 1'b1;
  localparam logic [CfgIdxW-1:0] CfgTopIdx  = '1;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata = '0;   // [7:0] rx_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutW-1:0]    m_axis_tdata;        // data_byte_0 [7:0] .. data_byte_7 [63:56]
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_data = '0;

  marker_frame_deframer_xor_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // deframer prediction state
  byte_t       start_mark = StartMarkerRst;
  byte_t       end_mark   = EndMarkerRst;
  logic        framing    = 1'b0;
  logic [CountW-1:0] taken = '0;
  frame_t      held       = '0;
  byte_t       fold_xor   = '0;

  byte_t  rx_pending_q[$];
  frame_t frames_due_q[$];

  int unsigned bytes_queued  = 0;
  int unsigned bytes_taken   = 0;
  int unsigned frames_seen   = 0;
  int unsigned errors        = 0;
  int unsigned cycles        = 0;
  int unsigned src_idle_pct  = IdlePct;
  int unsigned sink_idle_pct = IdlePct;

  function automatic void deframe_step(byte_t b);
    if (!framing) begin
      if (b == start_mark) begin
        framing  = 1'b1;
        taken    = '0;
        fold_xor = '0;
      end
    end else if (taken < CountEnd) begin
      held[taken[StoreIdxW-1:0]] = b;
      if (taken < CountCheck) fold_xor ^= b;
      taken++;
    end else begin
      // end byte closes the frame whether it is good or not
      if (b == end_mark && fold_xor == held[DataBytes-1]) frames_due_q.push_back(held);
      framing  = 1'b0;
      taken    = '0;
      fold_xor = '0;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d bytes left, %0d frames outstanding", $time,
               bytes_queued - bytes_taken, frames_due_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (rx_pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_pending_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // tracks accepted bytes and checks each output word
  always @(posedge clk_i) begin : result_monitor
    frame_t want;
    frame_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_step(s_axis_tdata);
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (frames_due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got %h", $time, got);
        end else begin
          want = frames_due_q.pop_front();
          frames_seen++;
          for (int i = 0; i < DataBytes; i++) begin
            if (got[i] !== want[i]) begin
              errors++;
              $display("%0t: data_byte_%0d expected %02h, got %02h", $time, i, want[i], got[i]);
            end
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic push_byte(byte_t b);
    rx_pending_q.push_back(b);
    bytes_queued++;
  endtask

  function automatic frame_t seal(frame_t f);
    byte_t x;
    x = '0;
    for (int i = 0; i < CheckBytes; i++) x ^= f[i];
    f[DataBytes-1] = x;
    return f;
  endfunction

  function automatic frame_t make_frame(bit bad_check);
    frame_t f;
    for (int i = 0; i < CheckBytes; i++)
      f[i] = ($urandom_range(9) == 0) ? start_mark : byte_t'($urandom);
    f = seal(f);
    if (bad_check) f[DataBytes-1] ^= byte_t'($urandom_range(255, 1));
    return f;
  endfunction

  task automatic push_frame(frame_t f, byte_t tail);
    push_byte(start_mark);
    for (int i = 0; i < DataBytes; i++) push_byte(f[i]);
    push_byte(tail);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, byte_t val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgStartMarker) start_mark = val;
    else if (idx == CfgEndMarker) end_mark = val;
  endtask

  // drain the byte queue, give pending frames a bounded time to come out
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (bytes_taken != bytes_queued) @(posedge clk_i);
    while (frames_due_q.size() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    if (frames_due_q.size() != 0) begin
      $display("%0t: %0d frames missing, expected %h first, got none", $time,
               frames_due_q.size(), frames_due_q[0]);
      errors += frames_due_q.size();
      frames_due_q.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    byte_t  start_set [6] = '{8'hAA, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00};
    byte_t  end_set   [6] = '{8'h55, 8'hFF, 8'h00, 8'h5A, 8'h00, 8'h00};
    frame_t f;
    byte_t  tail;
    int unsigned mark;
    int unsigned pick;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset markers: extremes and a start marker inside the data
    push_byte(end_mark);
    f = '0;
    f[1] = 8'hFF;
    f[2] = start_mark;
    f[3] = 8'h01;
    f[4] = 8'h80;
    f[5] = 8'h7F;
    f[6] = 8'hFE;
    push_frame(seal(f), end_mark);
    // start marker as the end byte drops the frame and opens nothing
    push_frame(make_frame(1'b0), start_mark);
    push_byte(end_mark);
    push_frame(make_frame(1'b1), end_mark);
    settle();

    // end marker changed halfway through a frame, ignored indexes in between
    f = make_frame(1'b0);
    push_byte(start_mark);
    for (int i = 0; i < 3; i++) push_byte(f[i]);
    settle();
    cfg_write(CfgEndMarker, 8'h3C);
    cfg_write(CfgTopIdx, 8'h00);
    cfg_write(CfgPastEnd, 8'h77);
    for (int i = 3; i < DataBytes; i++) push_byte(f[i]);
    push_byte(8'h3C);

    for (int p = 0; p < 6; p++) begin
      settle();
      // one phase runs with both sides at full rate
      src_idle_pct  = (p == 2) ? 0 : IdlePct;
      sink_idle_pct = (p == 2) ? 0 : IdlePct;
      if (p >= 4) begin
        start_set[p] = byte_t'($urandom);
        end_set[p]   = byte_t'($urandom);
      end
      cfg_write(CfgStartMarker, start_set[p]);
      cfg_write(CfgEndMarker, end_set[p]);
      if (p % 2 == 1)
        cfg_write(CfgIdxW'($urandom_range(CfgTopIdx, CfgPastEnd)), byte_t'($urandom));
      mark = bytes_queued;
      while (bytes_queued - mark < PhaseBytes) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          push_frame(make_frame(1'b0), end_mark);
        end else if (pick < 80) begin
          push_frame(make_frame(1'b1), end_mark);
        end else if (pick < 90) begin
          tail = byte_t'($urandom);
          if (tail == end_mark) tail = ~end_mark;
          if ($urandom_range(1) == 1 && start_mark != end_mark) tail = start_mark;
          push_frame(make_frame(1'b0), tail);
        end else begin
          repeat ($urandom_range(5, 1)) push_byte(byte_t'($urandom));
        end
      end
    end
    settle();

    $display("checked %0d frames out of %0d bytes over seven marker settings,", frames_seen,
             bytes_taken);
    $display("with bad checks, bad end bytes, noise and a mid-frame marker change");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== marker_frame_deframer_xor_check.f =====
design/mfdx_pkg.sv
design/marker_frame_deframer_xor_check.sv
tb/tb_marker_frame_deframer_xor_check.sv
